@@ src/sus_pkg.sv @@
// shared types and constants for the sorted unique key set
package sus_pkg;

    localparam int SUS_CAPACITY = 16;
    localparam int SUS_KEY_BITS = 16;

    localparam int SUS_IN_KEY_BITS  = 16;
    localparam int SUS_IN_KIND_BITS = 8;
    localparam int SUS_STATUS_BITS  = 3;
    localparam int SUS_COUNT_BITS   = 5;
    localparam int SUS_S_DATA_BITS  = 24;
    localparam int SUS_M_DATA_BITS  = 8;

    localparam logic [SUS_IN_KIND_BITS-1:0] SUS_KIND_RESET = 8'd3;

    localparam logic SUS_OP_INSERT = 1'b0;
    localparam logic SUS_OP_REMOVE = 1'b1;

    typedef enum logic [SUS_STATUS_BITS-1:0] {
        STATUS_INSERTED  = 3'd0,
        STATUS_DUPLICATE = 3'd1,
        STATUS_REMOVED   = 3'd2,
        STATUS_NOT_FOUND = 3'd3,
        STATUS_FILTERED  = 3'd4,
        STATUS_FULL      = 3'd5
    } status_t;

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } state_t;

    // per-cycle command broadcast to every cell
    typedef struct packed {
        logic shift_in;
        logic shift_out;
    } cell_ctrl_t;

endpackage

@@ src/sus_cell.sv @@
// one slot of the sorted key chain: compare against the request key and shift
module sus_cell #(
    parameter int KEY_BITS = sus_pkg::SUS_KEY_BITS
) (
    input  logic                aclk,
    input  sus_pkg::cell_ctrl_t ctrl,
    input  logic [KEY_BITS-1:0] req_key,
    input  logic                occupied,
    input  logic                left_lt,
    input  logic [KEY_BITS-1:0] left_key,
    input  logic [KEY_BITS-1:0] right_key,
    output logic [KEY_BITS-1:0] key,
    output logic                lt,
    output logic                eq
);
    import sus_pkg::*;

    logic [KEY_BITS-1:0] key_reg;
    logic [KEY_BITS-1:0] key_next;

    assign key = key_reg;
    assign lt  = occupied && (key_reg < req_key);
    assign eq  = occupied && (key_reg == req_key);

    always_comb begin
        key_next = key_reg;
        if (ctrl.shift_in && !lt) begin
            // first slot not below the key takes it, the rest move up
            key_next = left_lt ? req_key : left_key;
        end else if (ctrl.shift_out && !lt) begin
            key_next = right_key;
        end
    end

    always_ff @(posedge aclk) begin
        key_reg <= key_next;
    end

endmodule

@@ src/sorted_unique_key_set.sv @@
// top level of the sorted unique key set: request control and the cell chain
//
//  channel  | dir | payload                                   | beat when
//  ---------+-----+-------------------------------------------+------------------------
//  s_       | in  | tuser: operation; tdata: item_key, kind   | s_tvalid && s_tready
//  m_       | out | tdata: status, entry_count                | m_tvalid && m_tready
//  cfg_     | in  | cfg_data: max_accepted_kind               | cfg_valid && cfg_ready
//
//  each request is captured in the idle state and executed before the next beat is taken; in execute every cell
//  compares against the key in parallel and the chain shifts, count and status settle
//  reset (aresetn low, synchronous) empties the set and restores the kind limit to 3
//  the result sits in an output register; a stalled m_ side holds the next request
//  in the execute cycle until the register frees, no new beat is taken meanwhile
module sorted_unique_key_set #(
    parameter int CAPACITY = sus_pkg::SUS_CAPACITY,
    parameter int KEY_BITS = sus_pkg::SUS_KEY_BITS
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // request stream
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [sus_pkg::SUS_S_DATA_BITS-1:0] s_tdata,  // item_key[15:0], item_kind[23:16]
    input  logic                                s_tuser,  // operation[0]
    // result stream
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [sus_pkg::SUS_M_DATA_BITS-1:0] m_tdata,  // status[2:0], entry_count[7:3]
    // kind limit register
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [sus_pkg::SUS_IN_KIND_BITS-1:0] cfg_data
);
    import sus_pkg::*;

    localparam int CNT_BITS = $clog2(CAPACITY + 1);

    // state and handshake
    state_t state_reg;
    state_t state_next;
    logic   accept;
    logic   exec_fire;

    // captured request
    logic                        op_reg;
    logic [KEY_BITS-1:0]         key_reg;
    logic [SUS_IN_KIND_BITS-1:0] kind_reg;
    logic [SUS_IN_KIND_BITS-1:0] max_kind_reg;

    // set bookkeeping
    logic [CNT_BITS-1:0] count_reg;
    logic [CNT_BITS-1:0] count_next;
    logic                found;
    logic                full;
    status_t             status;
    cell_ctrl_t          ctrl;

    // result register
    logic                      m_valid_reg;
    status_t                   m_status_reg;
    logic [SUS_COUNT_BITS-1:0] m_count_reg;

    // chain wiring
    logic [KEY_BITS-1:0] cell_key [CAPACITY];
    logic [CAPACITY-1:0] cell_lt;
    logic [CAPACITY-1:0] cell_eq;

    logic [KEY_BITS+SUS_IN_KEY_BITS-1:0] key_wide;
    logic [CNT_BITS+SUS_COUNT_BITS-1:0]  count_wide;

    assign accept    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign key_wide  = {{KEY_BITS{1'b0}}, s_tdata[SUS_IN_KEY_BITS-1:0]};

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (s_tvalid) state_next = ST_EXEC;
            ST_EXEC: if (!m_valid_reg || m_tready) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        s_tready  = 1'b0;
        exec_fire = 1'b0;
        unique case (state_reg)
            ST_IDLE: s_tready  = 1'b1;
            ST_EXEC: exec_fire = !m_valid_reg || m_tready;
            default: s_tready  = 1'b0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // request capture, key trimmed or widened to the stored width
    always_ff @(posedge aclk) begin
        if (accept) begin
            op_reg   <= s_tuser;
            key_reg  <= key_wide[KEY_BITS-1:0];
            kind_reg <= s_tdata[SUS_IN_KEY_BITS +: SUS_IN_KIND_BITS];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_kind_reg <= SUS_KIND_RESET;
        end else if (cfg_valid && cfg_ready) begin
            max_kind_reg <= cfg_data;
        end
    end

    // decide the operation from the parallel compare
    assign found = |cell_eq;
    assign full  = (count_reg == CNT_BITS'(CAPACITY));

    always_comb begin
        status         = STATUS_FILTERED;
        ctrl.shift_in  = 1'b0;
        ctrl.shift_out = 1'b0;
        count_next     = count_reg;
        priority if (kind_reg > max_kind_reg) begin
            status = STATUS_FILTERED;
        end else if (op_reg == SUS_OP_INSERT) begin
            priority if (found) begin
                status = STATUS_DUPLICATE;
            end else if (full) begin
                status = STATUS_FULL;
            end else begin
                status        = STATUS_INSERTED;
                ctrl.shift_in = exec_fire;
                count_next    = count_reg + CNT_BITS'(1);
            end
        end else begin
            if (found) begin
                status         = STATUS_REMOVED;
                ctrl.shift_out = exec_fire;
                count_next     = count_reg - CNT_BITS'(1);
            end else begin
                status = STATUS_NOT_FOUND;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else if (exec_fire) begin
            count_reg <= count_next;
        end
    end

    // entry count shown in its 5-bit field
    assign count_wide = {{SUS_COUNT_BITS{1'b0}}, count_next};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (exec_fire) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (exec_fire) begin
            m_status_reg <= status;
            m_count_reg  <= count_wide[SUS_COUNT_BITS-1:0];
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {m_count_reg, m_status_reg};

    // chain of cells, slot 0 holds the smallest key
    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        logic                occ;
        logic                left_lt;
        logic [KEY_BITS-1:0] left_key;
        logic [KEY_BITS-1:0] right_key;

        assign occ = (CNT_BITS'(i) < count_reg);

        if (i == 0) begin : g_first
            // nothing to the left is ever at or above the key
            assign left_lt  = 1'b1;
            assign left_key = key_reg;
        end else begin : g_mid
            assign left_lt  = cell_lt[i-1];
            assign left_key = cell_key[i-1];
        end

        if (i == CAPACITY - 1) begin : g_last
            assign right_key = cell_key[i];
        end else begin : g_inner
            assign right_key = cell_key[i+1];
        end

        sus_cell #(
            .KEY_BITS (KEY_BITS)
        ) u_cell (
            .aclk      (aclk),
            .ctrl      (ctrl),
            .req_key   (key_reg),
            .occupied  (occ),
            .left_lt   (left_lt),
            .left_key  (left_key),
            .right_key (right_key),
            .key       (cell_key[i]),
            .lt        (cell_lt[i]),
            .eq        (cell_eq[i])
        );
    end

endmodule
